// File: rtl/core/sps_pkg.sv
package sps_pkg;

    // Default geometry of a scan point and a group count
    localparam int COORD_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF = 12;

    // Configuration port
    localparam int THR_W      = 24;
    localparam int SIZE_W     = 12;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [THR_W-1:0]  THR_RESET      = 24'd100;
    localparam logic [SIZE_W-1:0] MIN_SIZE_RESET = 12'd2;
    localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 12'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIST_THR = 2'd0,
        REG_MIN_SIZE = 2'd1,
        REG_MAX_SIZE = 2'd2
    } sps_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP_SQ,
        ST_STEP_CMP,
        ST_DECIDE,
        ST_CLOSE_CHK,
        ST_SPAN_SUM,
        ST_ITER_GO,
        ST_ITER_WAIT,
        ST_EMIT,
        ST_REOPEN,
        ST_LAST_CHK
    } sps_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;        // input channel may transfer
        logic sq_load;     // register the two squared differences
        logic sq_span;     // operands: group ends instead of new point and previous
        logic d2_load;     // register the squared distance and the near flag
        logic grp_start;
        logic grp_add;
        logic grp_close;
        logic iter_start;  // launch the dividers and the square root
        logic out_load;
        logic out_end;
    } sps_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pt_taken;    // an input point transfers this cycle
        logic in_group;
        logic near_pt;
        logic last;
        logic ok;
        logic iter_done;
        logic out_free;
    } sps_status_t;

endpackage

// File: rtl/core/sps_point_if.sv
interface sps_point_if #(
    parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

// File: rtl/core/sps_group_if.sv
interface sps_group_if #(
    parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = sps_pkg::COUNT_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] centre_x;
    logic [COORD_BITS-1:0] centre_y;
    logic [COORD_BITS:0]   span;
    logic [COUNT_BITS-1:0] point_count;
    logic                  group_valid;
    logic                  scan_end;

    modport source (output valid, output centre_x, output centre_y, output span,
                    output point_count, output group_valid, output scan_end,
                    input ready);
    modport sink   (input valid, input centre_x, input centre_y, input span,
                    input point_count, input group_valid, input scan_end,
                    output ready);
endinterface

// File: rtl/core/sps_div.sv
module sps_div #(
    parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = sps_pkg::COUNT_BITS_DEF,
    localparam int SUM_BITS  = COORD_BITS + COUNT_BITS,
    localparam int CNT_W     = $clog2(SUM_BITS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SUM_BITS-1:0]   dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic                  busy,
    output logic [COORD_BITS-1:0] mean
);

    logic [SUM_BITS-1:0]   dq_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] div_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic [COUNT_BITS:0]   rem_sh;
    logic [COUNT_BITS:0]   rem_sub;
    logic                  ge;
    logic [COUNT_BITS:0]   rem_dbl;
    logic                  inc;

    // Restoring division, one quotient bit a cycle
    always_comb
    begin
        rem_sh  = {rem_reg, dq_reg[SUM_BITS-1]};
        ge      = rem_sh >= {1'b0, div_reg};
        rem_sub = rem_sh - {1'b0, div_reg};
    end

    // Round to nearest, ties to the even quotient
    always_comb
    begin
        rem_dbl = {rem_reg, 1'b0};
        inc     = (rem_dbl > {1'b0, div_reg}) || ((rem_dbl == {1'b0, div_reg}) && dq_reg[0]);
        mean    = dq_reg[COORD_BITS-1:0] + {{(COORD_BITS-1){1'b0}}, inc};
    end

    assign busy = (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(SUM_BITS);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy)
        begin
            dq_reg  <= {dq_reg[SUM_BITS-2:0], ge};
            rem_reg <= ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        end
    end

endmodule

// File: rtl/core/sps_sqrt.sv
module sps_sqrt #(
    parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF,
    localparam int ROOT_W    = COORD_BITS + 1,
    localparam int VAL_W     = 2 * ROOT_W,
    localparam int D2_W      = 2 * COORD_BITS + 1,
    localparam int CNT_W     = $clog2(ROOT_W + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [D2_W-1:0]   value,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    logic [VAL_W-1:0]  val_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] rem_sub;
    logic              ge;

    // Digit by digit: two radicand bits in, one root bit out per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, val_reg[VAL_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = rem_sh >= trial;
        rem_sub = rem_sh - trial;
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(ROOT_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= VAL_W'(value);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy)
        begin
            val_reg  <= {val_reg[VAL_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

endmodule

// File: rtl/core/sps_datapath.sv
module sps_datapath #(
    parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = sps_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  sps_pkg::sps_cmd_t                   cmd,
    output sps_pkg::sps_status_t                status,
    sps_point_if.sink                           points,
    sps_group_if.source                         groups
);

    localparam int SUM_BITS = COORD_BITS + COUNT_BITS;
    localparam int SQ_W     = 2 * COORD_BITS;
    localparam int D2_W     = 2 * COORD_BITS + 1;
    localparam int SPAN_W   = COORD_BITS + 1;
    localparam int CMP_W    = (D2_W > sps_pkg::THR_W) ? D2_W : sps_pkg::THR_W;
    localparam int SZ_W     = (COUNT_BITS > sps_pkg::SIZE_W) ? COUNT_BITS : sps_pkg::SIZE_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration
    logic [sps_pkg::THR_W-1:0]  thr_reg;
    logic [sps_pkg::SIZE_W-1:0] min_reg;
    logic [sps_pkg::SIZE_W-1:0] max_reg;

    // Accepted point
    logic [COORD_BITS-1:0] x_in_reg;
    logic [COORD_BITS-1:0] y_in_reg;
    logic                  last_reg;

    // Open group
    logic                  in_group_reg;
    logic [COORD_BITS-1:0] prev_x_reg;
    logic [COORD_BITS-1:0] prev_y_reg;
    logic [COORD_BITS-1:0] first_x_reg;
    logic [COORD_BITS-1:0] first_y_reg;
    logic [SUM_BITS-1:0]   sum_x_reg;
    logic [SUM_BITS-1:0]   sum_y_reg;
    logic [COUNT_BITS-1:0] count_reg;

    // Distance
    logic [SQ_W-1:0]       sq_a_reg;
    logic [SQ_W-1:0]       sq_b_reg;
    logic [D2_W-1:0]       d2_reg;
    logic                  near_reg;

    // Result register
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] centre_x_reg;
    logic [COORD_BITS-1:0] centre_y_reg;
    logic [SPAN_W-1:0]     span_reg;
    logic [COUNT_BITS-1:0] point_count_reg;
    logic                  group_valid_reg;
    logic                  scan_end_reg;

    logic                  taken;
    logic [COORD_BITS-1:0] opa_x;
    logic [COORD_BITS-1:0] opb_x;
    logic [COORD_BITS-1:0] opa_y;
    logic [COORD_BITS-1:0] opb_y;
    logic [COORD_BITS-1:0] diff_x;
    logic [COORD_BITS-1:0] diff_y;
    logic [D2_W-1:0]       d2_sum;
    logic                  ok;
    logic                  out_free;
    logic                  div_x_busy;
    logic                  div_y_busy;
    logic                  sqrt_busy;
    logic [COORD_BITS-1:0] mean_x;
    logic [COORD_BITS-1:0] mean_y;
    logic [SPAN_W-1:0]     root;

    assign taken         = points.valid && cmd.take;
    assign points.ready  = cmd.take;

    assign groups.valid       = out_valid_reg;
    assign groups.centre_x    = centre_x_reg;
    assign groups.centre_y    = centre_y_reg;
    assign groups.span        = span_reg;
    assign groups.point_count = point_count_reg;
    assign groups.group_valid = group_valid_reg;
    assign groups.scan_end    = scan_end_reg;

    always_comb
    begin
        if (cmd.sq_span)
        begin
            opa_x = prev_x_reg;
            opb_x = first_x_reg;
            opa_y = prev_y_reg;
            opb_y = first_y_reg;
        end
        else
        begin
            opa_x = x_in_reg;
            opb_x = prev_x_reg;
            opa_y = y_in_reg;
            opb_y = prev_y_reg;
        end
        diff_x = (opa_x >= opb_x) ? (opa_x - opb_x) : (opb_x - opa_x);
        diff_y = (opa_y >= opb_y) ? (opa_y - opb_y) : (opb_y - opa_y);
        d2_sum = D2_W'(sq_a_reg) + D2_W'(sq_b_reg);
    end

    assign ok = in_group_reg && (SZ_W'(count_reg) >= SZ_W'(min_reg))
                             && (SZ_W'(count_reg) <= SZ_W'(max_reg));
    assign out_free = !out_valid_reg || groups.ready;

    always_comb
    begin
        status.pt_taken  = taken;
        status.in_group  = in_group_reg;
        status.near_pt   = near_reg;
        status.last      = last_reg;
        status.ok        = ok;
        status.iter_done = !(div_x_busy || div_y_busy || sqrt_busy);
        status.out_free  = out_free;
    end

    sps_div #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.iter_start),
        .dividend (sum_x_reg),
        .divisor  (count_reg),
        .busy     (div_x_busy),
        .mean     (mean_x)
    );

    sps_div #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.iter_start),
        .dividend (sum_y_reg),
        .divisor  (count_reg),
        .busy     (div_y_busy),
        .mean     (mean_y)
    );

    sps_sqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.iter_start),
        .value (d2_reg),
        .busy  (sqrt_busy),
        .root  (root)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= sps_pkg::THR_RESET;
            min_reg       <= sps_pkg::MIN_SIZE_RESET;
            max_reg       <= sps_pkg::MAX_SIZE_RESET;
            in_group_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    sps_pkg::REG_DIST_THR: thr_reg <= cfg_data[sps_pkg::THR_W-1:0];
                    sps_pkg::REG_MIN_SIZE: min_reg <= cfg_data[sps_pkg::SIZE_W-1:0];
                    sps_pkg::REG_MAX_SIZE: max_reg <= cfg_data[sps_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.grp_start)
            begin
                in_group_reg <= 1'b1;
            end
            else if (cmd.grp_close)
            begin
                in_group_reg <= 1'b0;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (groups.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (taken)
        begin
            x_in_reg <= points.point_x;
            y_in_reg <= points.point_y;
            last_reg <= points.last_point;
        end

        if (cmd.sq_load)
        begin
            sq_a_reg <= SQ_W'(diff_x) * SQ_W'(diff_x);
            sq_b_reg <= SQ_W'(diff_y) * SQ_W'(diff_y);
        end

        if (cmd.d2_load)
        begin
            d2_reg   <= d2_sum;
            near_reg <= CMP_W'(d2_sum) < CMP_W'(thr_reg);
        end

        if (cmd.grp_start)
        begin
            first_x_reg <= x_in_reg;
            first_y_reg <= y_in_reg;
            prev_x_reg  <= x_in_reg;
            prev_y_reg  <= y_in_reg;
            sum_x_reg   <= SUM_BITS'(x_in_reg);
            sum_y_reg   <= SUM_BITS'(y_in_reg);
            count_reg   <= COUNT_BITS'(1);
        end
        else if (cmd.grp_add)
        begin
            prev_x_reg <= x_in_reg;
            prev_y_reg <= y_in_reg;
            // freeze the sums once the count saturates
            if (count_reg != COUNT_MAX)
            begin
                sum_x_reg <= sum_x_reg + SUM_BITS'(x_in_reg);
                sum_y_reg <= sum_y_reg + SUM_BITS'(y_in_reg);
                count_reg <= count_reg + COUNT_BITS'(1);
            end
        end

        if (cmd.out_load)
        begin
            group_valid_reg <= ok;
            scan_end_reg    <= cmd.out_end;
            if (ok)
            begin
                centre_x_reg    <= mean_x;
                centre_y_reg    <= mean_y;
                span_reg        <= root;
                point_count_reg <= count_reg;
            end
            else
            begin
                centre_x_reg    <= '0;
                centre_y_reg    <= '0;
                span_reg        <= '0;
                point_count_reg <= '0;
            end
        end
    end

endmodule

// File: rtl/core/sps_ctrl.sv
module sps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sps_pkg::sps_status_t status,
    output sps_pkg::sps_cmd_t    cmd
);

    sps_pkg::sps_state_t state_reg;
    sps_pkg::sps_state_t state_next;
    logic                end_reg;
    logic                end_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sps_pkg::ST_IDLE;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            end_reg   <= end_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        end_next   = end_reg;
        cmd        = '0;
        cmd.out_end = end_reg;

        case (state_reg)
            sps_pkg::ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (status.pt_taken)
                begin
                    state_next = sps_pkg::ST_STEP_SQ;
                end
            end

            sps_pkg::ST_STEP_SQ:
            begin
                cmd.sq_load = 1'b1;
                state_next  = sps_pkg::ST_STEP_CMP;
            end

            sps_pkg::ST_STEP_CMP:
            begin
                cmd.d2_load = 1'b1;
                state_next  = sps_pkg::ST_DECIDE;
            end

            sps_pkg::ST_DECIDE:
            begin
                if (!status.in_group)
                begin
                    cmd.grp_start = 1'b1;
                    state_next    = sps_pkg::ST_LAST_CHK;
                end
                else if (status.near_pt)
                begin
                    cmd.grp_add = 1'b1;
                    state_next  = sps_pkg::ST_LAST_CHK;
                end
                else
                begin
                    end_next   = 1'b0;
                    state_next = sps_pkg::ST_CLOSE_CHK;
                end
            end

            sps_pkg::ST_CLOSE_CHK:
            begin
                if (status.ok)
                begin
                    cmd.sq_load = 1'b1;
                    cmd.sq_span = 1'b1;
                    state_next  = sps_pkg::ST_SPAN_SUM;
                end
                else if (end_reg)
                begin
                    state_next = sps_pkg::ST_EMIT;
                end
                else
                begin
                    // rejected on a breakpoint: drop the group silently
                    cmd.grp_close = 1'b1;
                    state_next    = sps_pkg::ST_REOPEN;
                end
            end

            sps_pkg::ST_SPAN_SUM:
            begin
                cmd.d2_load = 1'b1;
                state_next  = sps_pkg::ST_ITER_GO;
            end

            sps_pkg::ST_ITER_GO:
            begin
                cmd.iter_start = 1'b1;
                state_next     = sps_pkg::ST_ITER_WAIT;
            end

            sps_pkg::ST_ITER_WAIT:
            begin
                if (status.iter_done)
                begin
                    state_next = sps_pkg::ST_EMIT;
                end
            end

            sps_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.grp_close = 1'b1;
                    state_next    = end_reg ? sps_pkg::ST_IDLE : sps_pkg::ST_REOPEN;
                end
            end

            sps_pkg::ST_REOPEN:
            begin
                cmd.grp_start = 1'b1;
                state_next    = sps_pkg::ST_LAST_CHK;
            end

            sps_pkg::ST_LAST_CHK:
            begin
                if (status.last)
                begin
                    end_next   = 1'b1;
                    state_next = sps_pkg::ST_CLOSE_CHK;
                end
                else
                begin
                    state_next = sps_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/scan_point_segmenter_top.sv
// A point that joins or opens a group goes through the square, compare, decide and
// last-point check states before the input is ready again. Each emitted group also
// runs the bit-serial centroid dividers, which outlast the span square root beside them.
// A final point that does not join closes two groups: the one it breaks and its own.
// One point is in flight at a time; a result waits in the output register.
// Reset is asynchronous, active low: no open group, configuration at its defaults.
module scan_point_segmenter_top #(
    parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = sps_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data,
    sps_point_if.sink                      points,
    sps_group_if.source                    groups
);

    sps_pkg::sps_cmd_t    cmd;
    sps_pkg::sps_status_t status;

    sps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sps_datapath #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .points    (points),
        .groups    (groups)
    );

endmodule

// File: bench/scan_point_segmenter_checker.sv
`timescale 1ns / 100ps

module scan_point_segmenter_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data,
    sps_point_if                           points,
    sps_group_if                           groups,
    output int unsigned                    mismatches,
    output int unsigned                    pending,
    output int unsigned                    groups_checked
);

    localparam int COORD_W = sps_pkg::COORD_BITS_DEF;
    localparam int COUNT_W = sps_pkg::COUNT_BITS_DEF;
    localparam logic [COUNT_W-1:0] COUNT_FULL = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [COORD_W-1:0] centre_x;
        logic [COORD_W-1:0] centre_y;
        logic [COORD_W:0]   span;
        logic [COUNT_W-1:0] point_count;
        logic               group_valid;
        logic               scan_end;
    } group_rec_t;

    // Register copies, reset values as after reset
    logic [sps_pkg::THR_W-1:0]  dist_thr = sps_pkg::THR_RESET;
    logic [sps_pkg::SIZE_W-1:0] min_size = sps_pkg::MIN_SIZE_RESET;
    logic [sps_pkg::SIZE_W-1:0] max_size = sps_pkg::MAX_SIZE_RESET;

    // Segmentation state
    logic               open_group = 1'b0;
    logic [COORD_W-1:0] prev_x = '0;
    logic [COORD_W-1:0] prev_y = '0;
    logic [COORD_W-1:0] first_x = '0;
    logic [COORD_W-1:0] first_y = '0;
    logic [23:0]        sum_x = '0;
    logic [23:0]        sum_y = '0;
    logic [COUNT_W-1:0] grp_count = '0;

    group_rec_t  expected_groups[$];
    int unsigned fault_count = 0;
    int unsigned checked_count = 0;

    function automatic logic [31:0] dist_sq(input logic [COORD_W-1:0] ax,
                                            input logic [COORD_W-1:0] ay,
                                            input logic [COORD_W-1:0] bx,
                                            input logic [COORD_W-1:0] by);
        int dx;
        int dy;
        dx = ax;
        dx = dx - int'(bx);
        dy = ay;
        dy = dy - int'(by);
        return dx * dx + dy * dy;
    endfunction

    function automatic logic [COORD_W:0] floor_root(input logic [31:0] v);
        logic [COORD_W:0] root;
        logic [COORD_W:0] trial;
        root = '0;
        for (int b = COORD_W; b >= 0; b--)
        begin
            trial = root | ((COORD_W+1)'(1) << b);
            if (longint'(trial) * longint'(trial) <= longint'(v))
                root = trial;
        end
        return root;
    endfunction

    // Mean rounded to nearest, ties to the even quotient
    function automatic logic [COORD_W-1:0] rounded_mean(input logic [23:0] total,
                                                        input logic [COUNT_W-1:0] n);
        int unsigned q;
        int unsigned r;
        q = total / n;
        r = total % n;
        if (2 * r > n || (2 * r == n && q[0]))
            q++;
        return q[COORD_W-1:0];
    endfunction

    task automatic open_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        open_group = 1'b1;
        first_x = x;
        first_y = y;
        prev_x = x;
        prev_y = y;
        sum_x = 24'(x);
        sum_y = 24'(y);
        grp_count = COUNT_W'(1);
    endtask

    task automatic close_group(input logic scan_done);
        group_rec_t rec;
        logic       ok;
        ok = open_group && grp_count >= min_size && grp_count <= max_size;
        rec = '0;
        if (ok)
        begin
            rec.centre_x    = rounded_mean(sum_x, grp_count);
            rec.centre_y    = rounded_mean(sum_y, grp_count);
            rec.span        = floor_root(dist_sq(prev_x, prev_y, first_x, first_y));
            rec.point_count = grp_count;
            rec.group_valid = 1'b1;
        end
        rec.scan_end = scan_done;
        // a rejected group only shows when it ends the scan
        if (ok || scan_done)
            expected_groups = {expected_groups, rec};
        open_group = 1'b0;
    endtask

    task automatic segment_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                 input logic is_last);
        if (!open_group)
        begin
            open_at(x, y);
        end
        else if (dist_sq(x, y, prev_x, prev_y) < {8'd0, dist_thr})
        begin
            // freeze the sums once the count saturates
            if (grp_count != COUNT_FULL)
            begin
                sum_x = sum_x + 24'(x);
                sum_y = sum_y + 24'(y);
                grp_count = grp_count + 1'b1;
            end
            prev_x = x;
            prev_y = y;
        end
        else
        begin
            close_group(1'b0);
            open_at(x, y);
        end
        if (is_last)
            close_group(1'b1);
    endtask

    task automatic report_mismatch(input string what);
        fault_count++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("group record %0d %s: got %0d, expected %0d",
                                      checked_count, name, got, want));
    endtask

    task automatic take_group();
        group_rec_t want;
        checked_count++;
        if (expected_groups.size() == 0)
        begin
            report_mismatch($sformatf("group record %0d arrived with none expected",
                                      checked_count));
            return;
        end
        want = expected_groups.pop_front();
        compare_field("centre_x", 32'(groups.centre_x), 32'(want.centre_x));
        compare_field("centre_y", 32'(groups.centre_y), 32'(want.centre_y));
        compare_field("span", 32'(groups.span), 32'(want.span));
        compare_field("point_count", 32'(groups.point_count), 32'(want.point_count));
        compare_field("group_valid", 32'(groups.group_valid), 32'(want.group_valid));
        compare_field("scan_end", 32'(groups.scan_end), 32'(want.scan_end));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    sps_pkg::REG_DIST_THR: dist_thr = cfg_data[sps_pkg::THR_W-1:0];
                    sps_pkg::REG_MIN_SIZE: min_size = cfg_data[sps_pkg::SIZE_W-1:0];
                    sps_pkg::REG_MAX_SIZE: max_size = cfg_data[sps_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end
            // retire the older record before predicting from a new point
            if (groups.valid && groups.ready)
                take_group();
            if (points.valid && points.ready)
                segment_point(points.point_x, points.point_y, points.last_point);
        end
        mismatches     <= fault_count;
        pending        <= expected_groups.size();
        groups_checked <= checked_count;
    end

endmodule

// File: bench/scan_point_segmenter_top_test.sv
`timescale 1ns / 100ps

module scan_point_segmenter_top_test;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1950;
    localparam int PHASES       = 6;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sps_pkg::CFG_DATA_W-1:0] cfg_data;

    logic        sink_ready = 1'b0;
    int          ready_hold = 0;
    int          burst_left = 0;
    int          points_sent = 0;
    int          settings_used = 0;
    int unsigned cycle_count = 0;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned groups_checked;

    sps_point_if points ();
    sps_group_if groups ();

    assign groups.ready = sink_ready;

    scan_point_segmenter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .points    (points),
        .groups    (groups)
    );

    scan_point_segmenter_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .points         (points),
        .groups         (groups),
        .mismatches     (mismatches),
        .pending        (pending),
        .groups_checked (groups_checked)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run timed out with %0d group records outstanding", pending);
            $display("[scan_point_segmenter_top] ERROR");
            $finish;
        end
    end

    // Receiver: stall windows, long open stretches and per-cycle coin flips
    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    sink_ready <= 1'b0;
                    ready_hold <= $urandom_range(1, 12);
                end
                1:
                begin
                    sink_ready <= 1'b1;
                    ready_hold <= $urandom_range(20, 150);
                end
                default: sink_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    task automatic send_point(input logic [11:0] x, input logic [11:0] y,
                              input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) == 0)
                burst_left = $urandom_range(50, 200);
            else
                burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                points.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        points.valid      <= 1'b1;
        points.point_x    <= x;
        points.point_y    <= y;
        points.last_point <= is_last;
        @(posedge clk);
        while (!points.ready)
            @(posedge clk);
        burst_left--;
        points_sent++;
    endtask

    // Hold until every record is in and a closing point has had time to finish
    task automatic wait_idle();
        points.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [23:0] thr, input logic [11:0] min_sz,
                             input logic [11:0] max_sz);
        logic [11:0] pad;
        pad = 12'($urandom);
        cfg_wr_en <= 1'b1;
        cfg_index <= sps_pkg::REG_DIST_THR;
        cfg_data  <= thr;
        @(posedge clk);
        // upper data bits are junk for the size registers
        cfg_index <= sps_pkg::REG_MIN_SIZE;
        cfg_data  <= {pad, min_sz};
        @(posedge clk);
        pad = 12'($urandom);
        cfg_index <= sps_pkg::REG_MAX_SIZE;
        cfg_data  <= {pad, max_sz};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [11:0] nudge(input logic [11:0] c, input int lim);
        int v;
        v = c;
        v = v + $urandom_range(0, 2 * lim) - lim;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    // Scans of walking groups: mostly steps that join, some jumps and stray points
    task automatic random_scans(input int n_items, input logic [23:0] thr);
        int          sent;
        int          run_len;
        int          reach;
        logic [11:0] x;
        logic [11:0] y;
        logic        is_last;
        reach = 0;
        while (reach < 600 && 2 * (reach + 1) * (reach + 1) < int'(thr))
            reach++;
        sent = 0;
        while (sent < n_items)
        begin
            x = 12'($urandom_range(0, 4095));
            y = 12'($urandom_range(0, 4095));
            if ($urandom_range(0, 7) == 0)
                run_len = $urandom_range(20, 60);
            else
                run_len = $urandom_range(1, 12);
            for (int i = 0; i < run_len && sent < n_items; i++)
            begin
                is_last = (sent == n_items - 1) || ($urandom_range(0, 24) == 0);
                send_point(x, y, is_last);
                sent++;
                if ($urandom_range(0, 7) == 0)
                begin
                    x = 12'($urandom_range(0, 4095));
                    y = 12'($urandom_range(0, 4095));
                end
                else
                begin
                    x = nudge(x, reach + 1);
                    y = nudge(y, reach + 1);
                end
            end
        end
    endtask

    initial
    begin
        logic [23:0] thr;
        logic [11:0] lo;
        logic [11:0] hi;
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= sps_pkg::REG_DIST_THR;
        cfg_data          <= '0;
        points.valid      <= 1'b0;
        points.point_x    <= '0;
        points.point_y    <= '0;
        points.last_point <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register values straight out of reset
        send_point(12'd4095, 12'd4095, 1'b1);
        send_point(12'd0, 12'd0, 1'b0);
        send_point(12'd6, 12'd7, 1'b0);
        // exactly on the threshold: break
        send_point(12'd12, 12'd15, 1'b0);
        send_point(12'd13, 12'd15, 1'b0);
        // breakpoint and scan end on one point
        send_point(12'd4095, 12'd0, 1'b1);
        send_point(12'd1, 12'd4095, 1'b0);
        send_point(12'd2, 12'd4095, 1'b0);
        send_point(12'd3, 12'd4094, 1'b1);
        wait_idle();

        // nothing joins, zero minimum size
        configure(24'd0, 12'd0, 12'd4095);
        send_point(12'd5, 12'd5, 1'b0);
        send_point(12'd5, 12'd5, 1'b0);
        send_point(12'd0, 12'd4095, 1'b1);
        wait_idle();

        // limits out of order, widest threshold
        configure(24'hFFFFFF, 12'd50, 12'd10);
        send_point(12'd0, 12'd0, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b0);
        send_point(12'd4000, 12'd4000, 1'b1);
        wait_idle();

        configure(24'd2, 12'd1, 12'd1);
        send_point(12'd7, 12'd7, 1'b0);
        send_point(12'd8, 12'd7, 1'b0);
        send_point(12'd8, 12'd8, 1'b0);
        send_point(12'd10, 12'd8, 1'b1);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    thr = 24'($urandom_range(1, 400));
                    lo  = 12'($urandom_range(1, 3));
                    hi  = 12'($urandom_range(2, 40));
                end
                1:
                begin
                    thr = 24'($urandom_range(400, 200000));
                    lo  = 12'($urandom_range(0, 5));
                    hi  = 12'($urandom_range(1, 20));
                end
                2:
                begin
                    thr = 24'($urandom);
                    lo  = 12'($urandom);
                    hi  = 12'($urandom);
                end
                3:
                begin
                    thr = 24'hFFFFFF;
                    lo  = 12'd1;
                    hi  = 12'd4095;
                end
                4:
                begin
                    thr = 24'd1;
                    lo  = 12'd1;
                    hi  = 12'd2;
                end
                default:
                begin
                    thr = 24'($urandom_range(1, 5000));
                    lo  = 12'($urandom_range(1, 8));
                    hi  = 12'($urandom_range(1, 8));
                end
            endcase
            configure(thr, lo, hi);
            random_scans(RANDOM_ITEMS / PHASES, thr);
            wait_idle();
        end

        $display("sent %0d scan points under %0d register settings, with stalls both sides",
                 points_sent, settings_used);
        $display("compared %0d group records, %0d mismatches", groups_checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("[scan_point_segmenter_top] OK");
        else
            $display("[scan_point_segmenter_top] ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sps_pkg.sv
rtl/core/sps_point_if.sv
rtl/core/sps_group_if.sv
rtl/core/sps_div.sv
rtl/core/sps_sqrt.sv
rtl/core/sps_datapath.sv
rtl/core/sps_ctrl.sv
rtl/core/scan_point_segmenter_top.sv
bench/scan_point_segmenter_checker.sv
bench/scan_point_segmenter_top_test.sv
